### rtl/core/sgrc_pkg.sv
// ----------------------------------------------------------------------------
// sgrc_pkg: shared types and codes for the source/group route cache
// Transfer payloads, scan record passed between cells, commit broadcast.
// ----------------------------------------------------------------------------
package sgrc_pkg;

  localparam int LIVE_W = 7;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;

  localparam logic [1:0] RC_DONE    = 2'd0;
  localparam logic [1:0] RC_ABSENT  = 2'd1;
  localparam logic [1:0] RC_PRESENT = 2'd2;
  localparam logic [1:0] RC_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] source_addr;
    logic [31:0] group_addr;
    logic [7:0]  in_interface;
    logic [31:0] time_ms;
    logic [7:0]  entry_status;
  } req_t;

  typedef struct packed {
    logic [1:0]        result_code;
    logic [7:0]        hit_interface;
    logic [31:0]       hit_time_ms;
    logic [7:0]        hit_status;
    logic [LIVE_W-1:0] live_entries;
  } rsp_t;

  // Lookup record that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic        active;
    logic [31:0] source_addr;
    logic [31:0] group_addr;
    logic        hit;
    logic        free;
    logic [7:0]  hit_interface;
    logic [31:0] hit_time_ms;
    logic [7:0]  hit_status;
  } scan_t;

  // Write-back broadcast to all cells after a scan completes.
  typedef struct packed {
    logic        add;
    logic        del;
    logic [31:0] source_addr;
    logic [31:0] group_addr;
    logic [7:0]  in_interface;
    logic [31:0] time_ms;
    logic [7:0]  entry_status;
  } commit_t;

endpackage

### rtl/core/sgrc_cell.sv
// ----------------------------------------------------------------------------
// sgrc_cell: one route cache slot
// Hold one entry, check the passing scan record against it, mark itself as
// the hit or the first free slot, and apply the commit broadcast.
// ----------------------------------------------------------------------------
module sgrc_cell
  import sgrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  scan_t   scan_i,
  output scan_t   scan_o,
  input  commit_t commit_i
);

  logic        valid_r;
  logic [31:0] src_r;
  logic [31:0] grp_r;
  logic [7:0]  if_r;
  logic [31:0] tm_r;
  logic [7:0]  st_r;
  logic        hit_mark_r;
  logic        free_mark_r;
  scan_t       scan_r;
  scan_t       scan_nxt;
  logic        match;
  logic        claim;

  assign match = valid_r && !scan_i.hit && (src_r == scan_i.source_addr)
                 && (grp_r == scan_i.group_addr);
  assign claim = !valid_r && !scan_i.free;

  always_comb begin
    scan_nxt = scan_i;
    if (match) begin
      scan_nxt.hit           = 1'b1;
      scan_nxt.hit_interface = if_r;
      scan_nxt.hit_time_ms   = tm_r;
      scan_nxt.hit_status    = st_r;
    end
    if (claim) begin
      scan_nxt.free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      hit_mark_r  <= 1'b0;
      free_mark_r <= 1'b0;
      scan_r      <= '0;
    end else begin
      scan_r <= scan_nxt;
      if (scan_i.active) begin
        hit_mark_r  <= match;
        free_mark_r <= claim;
      end
      if (commit_i.del && hit_mark_r) begin
        valid_r <= 1'b0;
      end else if (commit_i.add && free_mark_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  // Entry payload: written only by an add that claimed this slot.
  always_ff @(posedge clk) begin
    if (commit_i.add && free_mark_r) begin
      src_r <= commit_i.source_addr;
      grp_r <= commit_i.group_addr;
      if_r  <= commit_i.in_interface;
      tm_r  <= commit_i.time_ms;
      st_r  <= commit_i.entry_status;
    end
  end

  assign scan_o = scan_r;

endmodule

### rtl/core/source_group_route_cache_core.sv
// ----------------------------------------------------------------------------
// source_group_route_cache_core: source/group keyed route cache
// Result path: last cell, finished-result register, then the output register.
// Accepts one item at a time; the lookup record walks the cell row one slot per
// cycle, and input stays stalled until the result has moved to the output register, so a held result blocks input.
// Reset: all slots empty, live count zero, both channels idle.
// ----------------------------------------------------------------------------
module source_group_route_cache_core
  import sgrc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Scan links: link 0 is the injected record, link TABLE_ENTRIES the tail.
  scan_t             chain [TABLE_ENTRIES+1];
  scan_t             tail;
  commit_t           commit;

  logic              busy_r;
  req_t              req_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              fin_pend_r;
  rsp_t              fin_r;
  rsp_t              fin_nxt;
  logic              out_valid_r;
  rsp_t              out_data_r;
  logic              in_acc;
  logic              out_free;
  logic              is_add;
  logic              is_del;
  logic [1:0]        code;

  // Accept one item at a time; the output register holds the previous result.
  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign out_free = !out_valid_r || !out_stall;

  // Inject a fresh lookup record into the first cell.
  always_comb begin
    chain[0]             = '0;
    chain[0].active      = in_acc;
    chain[0].source_addr = in_data.source_addr;
    chain[0].group_addr  = in_data.group_addr;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    sgrc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .scan_i   (chain[g]),
      .scan_o   (chain[g+1]),
      .commit_i (commit)
    );
  end

  assign tail = chain[TABLE_ENTRIES];

  // Mode three decodes as search, like mode two.
  assign is_add = (req_r.mode == MODE_ADD);
  assign is_del = (req_r.mode == MODE_DELETE);

  // Write back when the record leaves the last cell: add goes to the first
  // free slot it saw, delete clears the slot that matched.
  always_comb begin
    commit              = '0;
    commit.add          = tail.active && is_add && !tail.hit && tail.free;
    commit.del          = tail.active && is_del && tail.hit;
    commit.source_addr  = req_r.source_addr;
    commit.group_addr   = req_r.group_addr;
    commit.in_interface = req_r.in_interface;
    commit.time_ms      = req_r.time_ms;
    commit.entry_status = req_r.entry_status;
  end

  always_comb begin
    priority if (is_add) begin
      if (tail.hit) begin
        code = RC_PRESENT;
      end else if (tail.free) begin
        code = RC_DONE;
      end else begin
        code = RC_FULL;
      end
    end else if (tail.hit) begin
      code = RC_DONE;
    end else begin
      code = RC_ABSENT;
    end
  end

  // Live count: never drop below zero on delete.
  always_comb begin
    cnt_nxt = cnt_r;
    if (commit.add) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (commit.del && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Hit fields stay zero unless a cell matched; the injected record is clear.
  always_comb begin
    fin_nxt               = '0;
    fin_nxt.result_code   = code;
    fin_nxt.hit_interface = tail.hit_interface;
    fin_nxt.hit_time_ms   = tail.hit_time_ms;
    fin_nxt.hit_status    = tail.hit_status;
    fin_nxt.live_entries  = LIVE_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      fin_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (fin_pend_r && out_free) begin
        busy_r <= 1'b0;
      end
      if (tail.active) begin
        fin_pend_r <= 1'b1;
      end else if (out_free) begin
        fin_pend_r <= 1'b0;
      end
      if (fin_pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture request, finished result and output.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
    end
    if (tail.active) begin
      fin_r <= fin_nxt;
    end
    if (fin_pend_r && out_free) begin
      out_data_r <= fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_ENTRIES))
    else $error("live count above capacity");

  a_tail_busy : assert property (@(posedge clk) disable iff (!rst_n)
    tail.active |-> busy_r)
    else $error("scan record arrived with no item in flight");

  a_fin_busy : assert property (@(posedge clk) disable iff (!rst_n)
    fin_pend_r |-> busy_r && !tail.active)
    else $error("finished result pending outside a lookup");

  a_commit_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(commit.add && commit.del))
    else $error("add and delete committed together");

  a_tail_then_fin : assert property (@(posedge clk) disable iff (!rst_n)
    tail.active |=> fin_pend_r)
    else $error("completed scan did not produce a result");
`endif

endmodule
